// ----- rtl/pfcck_pkg.sv -----
// Shared constants, types and functions for the pixel format convert / color key block.
package pfcck_pkg;

  localparam int PIXEL_BITS    = 32;
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int TOP_W         = $clog2(PIXEL_BITS);
  localparam int QDEPTH        = 4;
  localparam int QAW           = $clog2(QDEPTH);
  localparam int QCW           = $clog2(QDEPTH + 1);
  localparam int CFG_AW        = 8;
  localparam int CFG_DW        = 32;

  localparam logic [CFG_AW-1:0] REG_RED_BITS      = 8'd0;
  localparam logic [CFG_AW-1:0] REG_GREEN_BITS    = 8'd1;
  localparam logic [CFG_AW-1:0] REG_BLUE_BITS     = 8'd2;
  localparam logic [CFG_AW-1:0] REG_SOURCE_MODE   = 8'd3;
  localparam logic [CFG_AW-1:0] REG_PALETTE_COUNT = 8'd4;
  localparam logic [CFG_AW-1:0] REG_USE_FIXED_KEY = 8'd5;
  localparam logic [CFG_AW-1:0] REG_KEY_INDEX     = 8'd6;

  localparam logic FUNC_PAL_WRITE = 1'b0;
  localparam logic FUNC_CONVERT   = 1'b1;

  localparam logic MODE_INDEXED = 1'b0;
  localparam logic MODE_DIRECT  = 1'b1;

  typedef struct packed {
    logic [31:0]      red_bits;
    logic [31:0]      green_bits;
    logic [31:0]      blue_bits;
    logic [TOP_W-1:0] red_top;
    logic [TOP_W-1:0] green_top;
    logic [TOP_W-1:0] blue_top;
    logic             source_mode;
    logic [8:0]       palette_count;
    logic             use_fixed_key;
    logic [7:0]       key_index;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] index;
    logic       first_pixel;
    logic       zero_word;
  } qentry_t;

  // Highest set bit of a mask within the pixel width; empty mask gives 0.
  function automatic logic [TOP_W-1:0] top_bit(input logic [31:0] m);
    logic [TOP_W-1:0] h;
    h = '0;
    for (int b = 0; b < PIXEL_BITS && b < 32; b++) begin
      if (m[b]) h = TOP_W'(b);
    end
    return h;
  endfunction

  // Align bit 7 of the channel with bit h, then mask.
  function automatic logic [31:0] place_channel(input logic [7:0] v, input logic [31:0] m,
                                                input logic [TOP_W-1:0] h);
    logic [38:0] sh;
    sh = {31'b0, v} << h;
    return sh[38:7] & m;
  endfunction

endpackage

// ----- rtl/pfcck_if.sv -----
// Channel interfaces: pixel request input, pixel result output, register write port.
interface pfcck_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       first_pixel;
  modport source(output valid, func, index, red, green, blue, first_pixel, input ready);
  modport sink(input valid, func, index, red, green, blue, first_pixel, output ready);
endinterface

interface pfcck_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic        opaque;
  modport source(output valid, pixel_word, opaque, input ready);
  modport sink(input valid, pixel_word, opaque, output ready);
endinterface

interface pfcck_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pfcck_pkg::CFG_AW-1:0]  addr;
  logic [pfcck_pkg::CFG_DW-1:0]  data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

// ----- rtl/pfcck_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pfcck_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pfcck_cfg.sv -----
// Configuration registers with precomputed top bit of each channel mask.
module pfcck_cfg (
  input  logic              clk,
  input  logic              rst,
  pfcck_cfg_if.sink         cfg_wr,
  output pfcck_pkg::cfg_t   cfg
);

  pfcck_pkg::cfg_t regs;

  assign cfg_wr.ready = 1'b1;
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.red_bits      <= 32'h00FF0000;
      regs.green_bits    <= 32'h0000FF00;
      regs.blue_bits     <= 32'h000000FF;
      regs.red_top       <= pfcck_pkg::top_bit(32'h00FF0000);
      regs.green_top     <= pfcck_pkg::top_bit(32'h0000FF00);
      regs.blue_top      <= pfcck_pkg::top_bit(32'h000000FF);
      regs.source_mode   <= pfcck_pkg::MODE_INDEXED;
      regs.palette_count <= '0;
      regs.use_fixed_key <= 1'b0;
      regs.key_index     <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.addr)
        pfcck_pkg::REG_RED_BITS: begin
          regs.red_bits <= cfg_wr.data;
          regs.red_top  <= pfcck_pkg::top_bit(cfg_wr.data);
        end
        pfcck_pkg::REG_GREEN_BITS: begin
          regs.green_bits <= cfg_wr.data;
          regs.green_top  <= pfcck_pkg::top_bit(cfg_wr.data);
        end
        pfcck_pkg::REG_BLUE_BITS: begin
          regs.blue_bits <= cfg_wr.data;
          regs.blue_top  <= pfcck_pkg::top_bit(cfg_wr.data);
        end
        pfcck_pkg::REG_SOURCE_MODE:   regs.source_mode   <= cfg_wr.data[0];
        pfcck_pkg::REG_PALETTE_COUNT: regs.palette_count <= cfg_wr.data[8:0];
        pfcck_pkg::REG_USE_FIXED_KEY: regs.use_fixed_key <= cfg_wr.data[0];
        pfcck_pkg::REG_KEY_INDEX:     regs.key_index     <= cfg_wr.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pfcck_front.sv -----
// Front end: accepts requests, writes the palette, looks up indexed pixels.
module pfcck_front (
  input  logic                clk,
  input  logic                rst,
  pfcck_in_if.sink            px_in,
  input  pfcck_pkg::cfg_t     cfg,
  input  logic                q_full,
  output logic                q_push,
  output pfcck_pkg::qentry_t  q_entry
);

  logic                        s1_valid;
  logic [7:0]                  s1_index;
  logic [23:0]                 s1_rgb;
  logic                        s1_first;
  logic                        s1_zero;
  logic                        accept;
  logic                        is_pixel;
  logic                        in_depth;
  logic                        pal_we;
  logic                        pal_re;
  logic [23:0]                 pal_rdata;
  logic [23:0]                 rgb_sel;

  assign px_in.ready = !s1_valid || !q_full;
  assign accept      = px_in.valid && px_in.ready;
  assign is_pixel    = (px_in.func == pfcck_pkg::FUNC_CONVERT);
  assign in_depth    = ({1'b0, px_in.index} < 9'(pfcck_pkg::PALETTE_DEPTH));
  assign pal_we      = accept && !is_pixel && in_depth;
  assign pal_re      = accept && is_pixel;

  pfcck_ram #(
    .WIDTH(24),
    .DEPTH(pfcck_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(px_in.index[pfcck_pkg::PAL_AW-1:0]),
    .wdata({px_in.red, px_in.green, px_in.blue}),
    .re   (pal_re),
    .raddr(px_in.index[pfcck_pkg::PAL_AW-1:0]),
    .rdata(pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= is_pixel;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_re) begin
      s1_index <= px_in.index;
      s1_rgb   <= {px_in.red, px_in.green, px_in.blue};
      s1_first <= px_in.first_pixel;
      s1_zero  <= (cfg.source_mode == pfcck_pkg::MODE_INDEXED) &&
                  (!in_depth || ({1'b0, px_in.index} >= cfg.palette_count));
    end
  end

  assign rgb_sel = (cfg.source_mode == pfcck_pkg::MODE_DIRECT) ? s1_rgb : pal_rdata;

  assign q_push              = s1_valid && !q_full;
  assign q_entry.red         = rgb_sel[23:16];
  assign q_entry.green       = rgb_sel[15:8];
  assign q_entry.blue        = rgb_sel[7:0];
  assign q_entry.index       = s1_index;
  assign q_entry.first_pixel = s1_first;
  assign q_entry.zero_word   = s1_zero;

endmodule

// ----- rtl/pfcck_queue.sv -----
// Small register FIFO between front and back ends.
module pfcck_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pfcck_pkg::qentry_t  push_entry,
  input  logic                pop,
  output pfcck_pkg::qentry_t  head,
  output logic                empty,
  output logic                full
);

  pfcck_pkg::qentry_t          slots [pfcck_pkg::QDEPTH];
  logic [pfcck_pkg::QAW-1:0]   wr_ptr;
  logic [pfcck_pkg::QAW-1:0]   rd_ptr;
  logic [pfcck_pkg::QCW-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == pfcck_pkg::QCW'(pfcck_pkg::QDEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue pop while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

// ----- rtl/pfcck_back.sv -----
// Back end: packs channels into the display word and evaluates the color key.
module pfcck_back (
  input  logic                clk,
  input  logic                rst,
  input  pfcck_pkg::cfg_t     cfg,
  input  pfcck_pkg::qentry_t  head,
  input  logic                q_empty,
  output logic                q_pop,
  pfcck_out_if.source         px_out
);

  logic        out_valid;
  logic [31:0] out_word;
  logic        out_opaque;
  logic [31:0] captured_key;
  logic [31:0] captured_key_next;
  logic [31:0] packed_word;
  logic [31:0] word;
  logic [31:0] key;
  logic [31:0] index_ext;
  logic        opaque;

  assign q_pop     = !q_empty && (!out_valid || px_out.ready);
  assign index_ext = {24'b0, head.index};

  assign packed_word =
    pfcck_pkg::place_channel(head.red,   cfg.red_bits,   cfg.red_top)   |
    pfcck_pkg::place_channel(head.green, cfg.green_bits, cfg.green_top) |
    pfcck_pkg::place_channel(head.blue,  cfg.blue_bits,  cfg.blue_top);

  always_comb begin
    captured_key_next = captured_key;
    if (cfg.source_mode == pfcck_pkg::MODE_DIRECT) begin
      word = packed_word;
      if (head.first_pixel) captured_key_next = packed_word;
      key    = captured_key_next;
      opaque = (word != key);
    end else begin
      word = head.zero_word ? 32'b0 : packed_word;
      if (head.first_pixel) captured_key_next = index_ext;
      key    = cfg.use_fixed_key ? {24'b0, cfg.key_index} : captured_key_next;
      opaque = (index_ext != key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      captured_key <= '0;
    end else begin
      if (q_pop) begin
        out_valid    <= 1'b1;
        captured_key <= captured_key_next;
      end else if (px_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_word   <= word;
      out_opaque <= opaque;
    end
  end

  assign px_out.valid      = out_valid;
  assign px_out.pixel_word = out_word;
  assign px_out.opaque     = out_opaque;

endmodule

// ----- rtl/pixel_format_convert_colorkey_unit.sv -----
// Path to result valid: lookup register, queue slot, pack/compare output register.
// One request per cycle when not stalled; palette writes finish at accept, no result.
// The palette RAM read port and the single pack/compare stage set the one-per-cycle rate.
// Reset (synchronous, active high) restores register defaults, clears the key and queue.
// Palette contents are not cleared; no clearing pass, requests taken right after reset.
// Top level of the pixel format convert / color key block.
module pixel_format_convert_colorkey_unit (
  input  logic          clk,
  input  logic          rst,
  pfcck_in_if.sink      px_in,
  pfcck_out_if.source   px_out,
  pfcck_cfg_if.sink     cfg_wr
);

  pfcck_pkg::cfg_t     cfg;
  pfcck_pkg::qentry_t  q_entry;
  pfcck_pkg::qentry_t  q_head;
  logic                q_push;
  logic                q_pop;
  logic                q_empty;
  logic                q_full;

  pfcck_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg_wr(cfg_wr),
    .cfg   (cfg)
  );

  pfcck_front u_front (
    .clk    (clk),
    .rst    (rst),
    .px_in  (px_in),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_entry(q_entry)
  );

  pfcck_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  pfcck_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (q_head),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .px_out (px_out)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for pixel_format_convert_colorkey_unit: directed and random requests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 190;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic       func;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       first_pixel;
  } pixel_req_t;

  typedef struct {
    logic [31:0] word;
    logic        opaque;
  } pixel_res_t;

  typedef struct {
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
    logic        source_mode;
    logic [8:0]  palette_count;
    logic        use_fixed_key;
    logic [7:0]  key_index;
  } reg_set_t;

  class pixel_tracker;
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
    logic        source_mode;
    logic [8:0]  palette_count;
    logic        use_fixed_key;
    logic [7:0]  key_index;
    logic [23:0] palette [pfcck_pkg::PALETTE_DEPTH];
    logic [31:0] captured_key;
    pixel_res_t  expected_pixels[$];
    int          errors;

    function new();
      red_bits      = 32'h00FF_0000;
      green_bits    = 32'h0000_FF00;
      blue_bits     = 32'h0000_00FF;
      source_mode   = pfcck_pkg::MODE_INDEXED;
      palette_count = '0;
      use_fixed_key = 1'b0;
      key_index     = '0;
      captured_key  = '0;
      errors        = 0;
    endfunction

    function logic [31:0] align_channel(logic [7:0] v, logic [31:0] m);
      int          h;
      logic [63:0] w;
      h = -1;
      for (int b = 0; b < pfcck_pkg::PIXEL_BITS && b < 32; b++) begin
        if (m[b]) h = b;
      end
      if (h < 0) return '0;
      w = {56'b0, v};
      if (h >= 7) w = w << (h - 7);
      else w = w >> (7 - h);
      return w[31:0] & m;
    endfunction

    function logic [31:0] pack_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return align_channel(r, red_bits) | align_channel(g, green_bits)
           | align_channel(b, blue_bits);
    endfunction

    function void write_reg(logic [pfcck_pkg::CFG_AW-1:0] addr, logic [31:0] data);
      case (addr)
        pfcck_pkg::REG_RED_BITS:      red_bits = data;
        pfcck_pkg::REG_GREEN_BITS:    green_bits = data;
        pfcck_pkg::REG_BLUE_BITS:     blue_bits = data;
        pfcck_pkg::REG_SOURCE_MODE:   source_mode = data[0];
        pfcck_pkg::REG_PALETTE_COUNT: palette_count = data[8:0];
        pfcck_pkg::REG_USE_FIXED_KEY: use_fixed_key = data[0];
        pfcck_pkg::REG_KEY_INDEX:     key_index = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_request(pixel_req_t rq);
      pixel_res_t  res;
      logic [31:0] key;
      if (rq.func == pfcck_pkg::FUNC_PAL_WRITE) begin
        palette[rq.index] = {rq.red, rq.green, rq.blue};
        return;
      end
      if (source_mode == pfcck_pkg::MODE_DIRECT) begin
        res.word = pack_pixel(rq.red, rq.green, rq.blue);
        if (rq.first_pixel) captured_key = res.word;
        res.opaque = (res.word != captured_key);
      end else begin
        res.word = '0;
        if ({1'b0, rq.index} < palette_count) begin
          res.word = pack_pixel(palette[rq.index][23:16], palette[rq.index][15:8],
                                palette[rq.index][7:0]);
        end
        if (rq.first_pixel) captured_key = {24'b0, rq.index};
        key = use_fixed_key ? {24'b0, key_index} : captured_key;
        res.opaque = ({24'b0, rq.index} != key);
      end
      expected_pixels.push_back(res);
    endfunction

    function void check_pixel(logic [31:0] word, logic opaque);
      pixel_res_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual word %h opaque %b",
                 $time, word, opaque);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (word !== want.word) begin
        $display("%0t: pixel_word mismatch, expected %h actual %h", $time, want.word, word);
        errors++;
      end
      if (opaque !== want.opaque) begin
        $display("%0t: opaque mismatch, expected %b actual %b", $time, want.opaque, opaque);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;
  bit   pal_loaded [pfcck_pkg::PALETTE_DEPTH];
  int   items_sent;
  int   stall_left;
  int   cycles;
  pixel_tracker sb;

  pfcck_in_if  px_in();
  pfcck_out_if px_out();
  pfcck_cfg_if cfg_wr();

  pixel_format_convert_colorkey_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .px_in  (px_in),
    .px_out (px_out),
    .cfg_wr (cfg_wr)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      px_out.ready <= 1'b0;
      stall_left--;
    end else if (!steady && $urandom_range(7) == 0) begin
      px_out.ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      px_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && px_out.valid === 1'b1 && px_out.ready === 1'b1) begin
      sb.check_pixel(px_out.pixel_word, px_out.opaque);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** pixel_format_convert_colorkey_unit: FAILED **");
      $finish;
    end
  end

  task automatic push_req(input pixel_req_t rq);
    @(negedge clk);
    if (!steady && $urandom_range(5) == 0) begin
      px_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    px_in.valid       <= 1'b1;
    px_in.func        <= rq.func;
    px_in.index       <= rq.index;
    px_in.red         <= rq.red;
    px_in.green       <= rq.green;
    px_in.blue        <= rq.blue;
    px_in.first_pixel <= rq.first_pixel;
    do @(posedge clk); while (px_in.ready !== 1'b1);
    sb.note_request(rq);
    items_sent++;
  endtask

  task automatic send_write(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    pixel_req_t rq;
    rq.func        = pfcck_pkg::FUNC_PAL_WRITE;
    rq.index       = idx;
    rq.red         = r;
    rq.green       = g;
    rq.blue        = b;
    rq.first_pixel = 1'($urandom_range(1));
    pal_loaded[idx] = 1'b1;
    push_req(rq);
  endtask

  // Entries below palette_count must hold data before they are looked up.
  task automatic send_convert(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic first);
    pixel_req_t rq;
    if (sb.source_mode == pfcck_pkg::MODE_INDEXED && {1'b0, idx} < sb.palette_count &&
        !pal_loaded[idx])
      send_write(idx, 8'($urandom), 8'($urandom), 8'($urandom));
    rq.func        = pfcck_pkg::FUNC_CONVERT;
    rq.index       = idx;
    rq.red         = r;
    rq.green       = g;
    rq.blue        = b;
    rq.first_pixel = first;
    push_req(rq);
  endtask

  task automatic write_register(input logic [pfcck_pkg::CFG_AW-1:0] addr,
                                input logic [31:0] data);
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.addr  <= addr;
    cfg_wr.data  <= data;
    do @(posedge clk); while (cfg_wr.ready !== 1'b1);
    sb.write_reg(addr, data);
  endtask

  task automatic apply_settings(input reg_set_t s);
    @(negedge clk);
    px_in.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_register(pfcck_pkg::REG_RED_BITS, s.red_bits);
    write_register(pfcck_pkg::REG_GREEN_BITS, s.green_bits);
    write_register(pfcck_pkg::REG_BLUE_BITS, s.blue_bits);
    write_register(pfcck_pkg::REG_SOURCE_MODE, {31'b0, s.source_mode});
    write_register(pfcck_pkg::REG_PALETTE_COUNT, {23'b0, s.palette_count});
    write_register(pfcck_pkg::REG_USE_FIXED_KEY, {31'b0, s.use_fixed_key});
    write_register(pfcck_pkg::REG_KEY_INDEX, {24'b0, s.key_index});
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0000_0001;
      3:       return 32'h8000_0000;
      4:       return 32'h00FF_0000;
      5:       return 32'h0000_FF00;
      6:       return 32'h0000_00FF;
      7:       return 32'h0000_F800;
      8:       return 32'h0000_07E0;
      9:       return 32'h0000_001F;
      10:      return $urandom;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  initial begin
    reg_set_t    s;
    logic [7:0]  idx;
    logic [7:0]  key_idx;
    logic [23:0] rgb;
    logic [23:0] key_rgb;
    logic        first;
    int          start;
    int          pick;

    rst               = 1'b1;
    steady            = 1'b0;
    items_sent        = 0;
    stall_left        = 0;
    cycles            = 0;
    px_in.valid       = 1'b0;
    px_in.func        = pfcck_pkg::FUNC_PAL_WRITE;
    px_in.index       = '0;
    px_in.red         = '0;
    px_in.green       = '0;
    px_in.blue        = '0;
    px_in.first_pixel = 1'b0;
    px_out.ready      = 1'b0;
    cfg_wr.valid      = 1'b0;
    cfg_wr.addr       = '0;
    cfg_wr.data       = '0;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // indexed, first-pixel key
    s = '{32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, pfcck_pkg::MODE_INDEXED, 9'd256,
          1'b0, 8'd0};
    apply_settings(s);
    send_write(8'h00, 8'hFF, 8'h00, 8'h80);
    send_write(8'hFF, 8'h00, 8'hFF, 8'h01);
    send_write(8'h5A, 8'hA5, 8'h5A, 8'hFF);
    send_convert(8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    send_convert(8'h00, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    send_convert(8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    send_convert(8'h5A, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

    // fixed key, indices within and past the palette count
    s = '{32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, pfcck_pkg::MODE_INDEXED, 9'd1,
          1'b1, 8'd255};
    apply_settings(s);
    send_convert(8'h00, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    send_convert(8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    send_convert(8'h5A, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);

    // direct, full / single-bit / empty masks
    s = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, pfcck_pkg::MODE_DIRECT, 9'd0,
          1'b1, 8'd0};
    apply_settings(s);
    send_write(8'h10, 8'h12, 8'h34, 8'h56);
    send_convert(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_convert(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_convert(8'h33, 8'h00, 8'h00, 8'h00, 1'b0);
    send_convert(8'hCC, 8'h80, 8'h01, 8'h7F, 1'b0);

    // direct, top bit and 565 masks; distinct colors packing to the key
    s = '{32'h8000_0000, 32'h0000_07E0, 32'h0000_001F, pfcck_pkg::MODE_DIRECT, 9'd0,
          1'b0, 8'd0};
    apply_settings(s);
    send_convert(8'h00, 8'h01, 8'h80, 8'hFF, 1'b0);
    send_convert(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_convert(8'h00, 8'hFF, 8'hFE, 8'hF8, 1'b0);

    // back to indexed without a new first pixel
    s = '{32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, pfcck_pkg::MODE_INDEXED, 9'd256,
          1'b0, 8'd0};
    apply_settings(s);
    send_convert(8'h5A, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

    key_idx = '0;
    key_rgb = '0;
    for (int p = 0; p < PHASES; p++) begin
      s.red_bits      = pick_mask();
      s.green_bits    = pick_mask();
      s.blue_bits     = pick_mask();
      s.source_mode   = 1'($urandom_range(1));
      case ($urandom_range(5))
        0:       s.palette_count = 9'd0;
        1:       s.palette_count = 9'd1;
        2:       s.palette_count = 9'd255;
        3:       s.palette_count = 9'd256;
        default: s.palette_count = 9'($urandom_range(256));
      endcase
      s.use_fixed_key = 1'($urandom_range(1));
      case ($urandom_range(2))
        0:       s.key_index = 8'd0;
        1:       s.key_index = 8'd255;
        default: s.key_index = 8'($urandom);
      endcase
      apply_settings(s);
      if (p == PHASES - 1) steady = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 12) begin
          send_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          first = ($urandom_range(24) == 0);
          pick  = $urandom_range(9);
          if (sb.source_mode == pfcck_pkg::MODE_INDEXED) begin
            if (pick < 3) begin
              idx = sb.use_fixed_key ? sb.key_index : key_idx;
            end else if (pick < 5) begin
              case ($urandom_range(3))
                0:       idx = 8'h00;
                1:       idx = 8'hFF;
                2:       idx = sb.palette_count[7:0] - 8'd1;
                default: idx = sb.palette_count[7:0];
              endcase
            end else begin
              idx = 8'($urandom);
            end
            if (first) key_idx = idx;
            send_convert(idx, 8'($urandom), 8'($urandom), 8'($urandom), first);
          end else begin
            if (pick < 3) begin
              rgb = key_rgb;
            end else if (pick < 5) begin
              rgb[23:16] = $urandom_range(1) ? 8'hFF : 8'h00;
              rgb[15:8]  = $urandom_range(1) ? 8'hFF : 8'h00;
              rgb[7:0]   = $urandom_range(1) ? 8'hFF : 8'h00;
            end else begin
              rgb = 24'($urandom);
            end
            if (first) key_rgb = rgb;
            send_convert(8'($urandom), rgb[23:16], rgb[15:8], rgb[7:0], first);
          end
        end
      end
    end

    @(negedge clk);
    px_in.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** pixel_format_convert_colorkey_unit: PASSED **");
    end else begin
      $display("** pixel_format_convert_colorkey_unit: FAILED **");
    end
    $finish;
  end

endmodule
